// ===== hw/rtl/nscf_pkg.sv =====
package nscf_pkg;

	// Sentence body length limit and its index width
	localparam int MAX_BODY_LEN = 80;
	localparam int BLEN_W       = 7;

	// Header layout
	localparam int NUM_TYPES = 3;
	localparam int HDR_LEN   = 6;
	localparam int HCNT_W    = 3;

	typedef logic [7:0] byte_t;

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		TYPE_RMC = 2'd0,
		TYPE_GGA = 2'd1,
		TYPE_GSA = 2'd2
	} sent_type_t;

	localparam byte_t CHAR_STAR = 8'h2A;  // '*'
	localparam byte_t CHAR_CR   = 8'h0D;  // carriage return
	localparam byte_t CHAR_0    = 8'h30;  // '0'
	localparam byte_t CHAR_9    = 8'h39;  // '9'
	localparam byte_t HEX_ALPHA = 8'h37;  // 'A' - 10

	// Header text, one row per sentence type
	localparam byte_t HDR_TEXT [NUM_TYPES][HDR_LEN] = '{
		'{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43, 8'h2C},  // GPRMC,
		'{8'h47, 8'h50, 8'h47, 8'h47, 8'h41, 8'h2C},  // GPGGA,
		'{8'h47, 8'h50, 8'h47, 8'h53, 8'h41, 8'h2C}   // GPGSA,
	};

	// XOR of all header characters, seeds the running checksum
	function automatic byte_t hdr_sum(input int unsigned t);
		byte_t s;
		s = '0;
		for (int k = 0; k < HDR_LEN; k++) begin
			s = s ^ HDR_TEXT[t][k];
		end
		return s;
	endfunction

	// Checksum digit value: decimal digits, otherwise letter mapping mod 256
	function automatic byte_t hex_value(input byte_t c);
		byte_t v;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			v = c - CHAR_0;
		end else begin
			v = c - HEX_ALPHA;
		end
		return v;
	endfunction

endpackage

// ===== hw/rtl/nmea_sentence_checksum_framer.sv =====
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------------
// input   | in_valid / in_ready  | opcode, char_in
// output  | out_valid / out_ready| store_en, sentence_type, store_index, store_byte,
//         |                      | accepted, checksum_fail, ready_mask
//
// One result per input item; an accepted item is held in the input register and then
// loaded into the result register, where out_valid rises and the result waits for out_ready.
// Throughput is one item per cycle while out_ready holds: the framing state updates
// as an item moves from the input register to the result register.
// arst_n clears valid bits, framing state, match counters and ready flags.
// A stall on the output holds the result register and then the input register;
// in_ready drops only when both are full and out_ready is low.
module nmea_sentence_checksum_framer
	import nscf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	input  logic [7:0]        char_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              store_en,
	output logic [1:0]        sentence_type,
	output logic [BLEN_W-1:0] store_index,
	output logic [7:0]        store_byte,
	output logic              accepted,
	output logic              checksum_fail,
	output logic [2:0]        ready_mask
);

	// Input register
	logic  v_s1;
	logic  opcode_s1;
	byte_t char_s1;

	// Result register
	logic              v_s2;
	logic              store_en_s2;
	logic [1:0]        type_s2;
	logic [BLEN_W-1:0] index_s2;
	byte_t             byte_s2;
	logic              acc_s2;
	logic              fail_s2;
	logic [2:0]        mask_s2;

	// Framing state
	logic              in_sent_q;
	logic [HCNT_W-1:0] hdr_cnt_q [NUM_TYPES];
	logic [1:0]        act_type_q;
	logic [BLEN_W-1:0] body_len_q;
	byte_t             calc_sum_q;
	byte_t             rx_sum_q;
	logic [6:0]        hex_cnt_q;
	logic [2:0]        flags_q;

	// Next state and result
	logic              in_sent_d;
	logic [HCNT_W-1:0] hdr_cnt_d [NUM_TYPES];
	logic [1:0]        act_type_d;
	logic [BLEN_W-1:0] body_len_d;
	byte_t             calc_sum_d;
	byte_t             rx_sum_d;
	logic [6:0]        hex_cnt_d;
	logic [2:0]        flags_d;
	logic              r_store_en;
	logic [1:0]        r_type;
	logic [BLEN_W-1:0] r_index;
	byte_t             r_byte;
	logic              r_acc;
	logic              r_fail;

	logic adv_s2;
	logic adv_s1;

	// Handshake: result register moves when empty or taken
	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = v_s1 && adv_s2;
	assign in_ready = !v_s1 || adv_s2;

	// Step logic
	always_comb begin
		logic              found;
		logic              finish;
		logic [2:0]        bit_m;
		byte_t             rs_cur;
		logic [6:0]        hc_cur;
		logic [BLEN_W-1:0] len_inc;
		in_sent_d  = in_sent_q;
		act_type_d = act_type_q;
		body_len_d = body_len_q;
		calc_sum_d = calc_sum_q;
		rx_sum_d   = rx_sum_q;
		hex_cnt_d  = hex_cnt_q;
		flags_d    = flags_q;
		for (int i = 0; i < NUM_TYPES; i++) begin
			hdr_cnt_d[i] = hdr_cnt_q[i];
		end
		r_store_en = 1'b0;
		r_type     = TYPE_RMC;
		r_index    = '0;
		r_byte     = '0;
		r_acc      = 1'b0;
		r_fail     = 1'b0;
		found      = 1'b0;
		finish     = 1'b0;
		bit_m      = '0;
		rs_cur     = rx_sum_q;
		hc_cur     = hex_cnt_q;
		len_inc    = body_len_q + BLEN_W'(1);

		if (opcode_s1 == OP_RELEASE) begin
			if (flags_q == 3'b111) begin
				flags_d = '0;
			end
		end else if (!in_sent_q) begin
			// Header hunt, first completed header wins
			for (int i = 0; i < NUM_TYPES; i++) begin
				if (!found) begin
					if (hdr_cnt_q[i] < HCNT_W'(HDR_LEN) &&
					    char_s1 == HDR_TEXT[i][hdr_cnt_q[i]]) begin
						hdr_cnt_d[i] = hdr_cnt_q[i] + HCNT_W'(1);
						if (hdr_cnt_q[i] == HCNT_W'(HDR_LEN - 1)) begin
							found      = 1'b1;
							act_type_d = 2'(i);
							r_type     = 2'(i);
							calc_sum_d = hdr_sum(i);
						end
					end else begin
						hdr_cnt_d[i] = '0;
					end
				end
			end
			if (found) begin
				in_sent_d  = 1'b1;
				body_len_d = '0;
				for (int i = 0; i < NUM_TYPES; i++) begin
					hdr_cnt_d[i] = '0;
				end
			end
		end else begin
			r_type = act_type_q;
			case (act_type_q)
				TYPE_RMC: bit_m = 3'b001;
				TYPE_GGA: bit_m = 3'b010;
				TYPE_GSA: bit_m = 3'b100;
				default:  bit_m = 3'b000;
			endcase
			if ((flags_q & bit_m) != '0) begin
				// Type already pending: drop the sentence
				finish = 1'b1;
			end else begin
				if (body_len_q == '0) begin
					rs_cur = '0;
					hc_cur = '0;
				end
				rx_sum_d  = rs_cur;
				hex_cnt_d = hc_cur;
				if (char_s1 == CHAR_CR) begin
					if (rs_cur == calc_sum_q) begin
						flags_d = flags_q | bit_m;
						r_acc   = 1'b1;
					end else begin
						r_fail = 1'b1;
					end
					finish = 1'b1;
				end else begin
					if (char_s1 == CHAR_STAR) begin
						rx_sum_d  = '0;
						hex_cnt_d = 7'd1;
					end else if (hc_cur != '0) begin
						rx_sum_d = rs_cur | hex_value(char_s1);
						if (hc_cur == 7'd1) begin
							rx_sum_d = {rx_sum_d[3:0], 4'h0};
						end
						if (hc_cur != 7'd127) begin
							hex_cnt_d = hc_cur + 7'd1;
						end
					end else begin
						calc_sum_d = calc_sum_q ^ char_s1;
					end
					r_store_en = 1'b1;
					r_index    = body_len_q;
					r_byte     = char_s1;
				end
			end
			if (!finish) begin
				body_len_d = len_inc;
			end
			if (finish || len_inc >= BLEN_W'(MAX_BODY_LEN)) begin
				in_sent_d = 1'b0;
				for (int i = 0; i < NUM_TYPES; i++) begin
					hdr_cnt_d[i] = '0;
				end
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			char_s1   <= char_in;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			store_en_s2 <= r_store_en;
			type_s2     <= r_type;
			index_s2    <= r_index;
			byte_s2     <= r_byte;
			acc_s2      <= r_acc;
			fail_s2     <= r_fail;
			mask_s2     <= flags_d;
		end
	end

	// Framing state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q  <= 1'b0;
			act_type_q <= TYPE_RMC;
			body_len_q <= '0;
			calc_sum_q <= '0;
			rx_sum_q   <= '0;
			hex_cnt_q  <= '0;
			flags_q    <= '0;
			for (int i = 0; i < NUM_TYPES; i++) begin
				hdr_cnt_q[i] <= '0;
			end
		end else if (adv_s1) begin
			in_sent_q  <= in_sent_d;
			act_type_q <= act_type_d;
			body_len_q <= body_len_d;
			calc_sum_q <= calc_sum_d;
			rx_sum_q   <= rx_sum_d;
			hex_cnt_q  <= hex_cnt_d;
			flags_q    <= flags_d;
			for (int i = 0; i < NUM_TYPES; i++) begin
				hdr_cnt_q[i] <= hdr_cnt_d[i];
			end
		end
	end

	assign out_valid     = v_s2;
	assign store_en      = store_en_s2;
	assign sentence_type = type_s2;
	assign store_index   = index_s2;
	assign store_byte    = byte_s2;
	assign accepted      = acc_s2;
	assign checksum_fail = fail_s2;
	assign ready_mask    = mask_s2;

	// Checks
	a_acc_fail_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(accepted && checksum_fail))
		else $error("accepted and checksum_fail both set");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && store_en) |-> (store_index < BLEN_W'(MAX_BODY_LEN)))
		else $error("store_index beyond body limit");

	a_acc_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |->
			((sentence_type == TYPE_RMC && ready_mask[0]) ||
			 (sentence_type == TYPE_GGA && ready_mask[1]) ||
			 (sentence_type == TYPE_GSA && ready_mask[2])))
		else $error("accepted sentence without its ready flag");

	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_cnt_q[0] < HCNT_W'(HDR_LEN)) && (hdr_cnt_q[1] < HCNT_W'(HDR_LEN)) &&
		(hdr_cnt_q[2] < HCNT_W'(HDR_LEN)))
		else $error("header match counter overrun");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nscf_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int ITEM_TARGET = 1600;

	// Checksum seed per sentence type: XOR of "GPRMC,", "GPGGA,", "GPGSA,"
	localparam byte_t HDR_SEED [NUM_TYPES] = '{8'h67, 8'h7A, 8'h6E};

	// One result of the framer, field for field
	typedef struct packed {
		logic              store_en;
		sent_type_t        kind;
		logic [BLEN_W-1:0] index;
		byte_t             data;
		logic              sum_ok;
		logic              sum_bad;
		logic [2:0]        flags;
	} frame_out_t;

	// Directed row bookkeeping: typed expectation or predictor
	typedef struct {
		bit         typed;
		frame_out_t want;
	} typed_out_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              opcode = 1'b0;
	logic [7:0]        char_in = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              store_en;
	logic [1:0]        sentence_type;
	logic [BLEN_W-1:0] store_index;
	logic [7:0]        store_byte;
	logic              accepted;
	logic              checksum_fail;
	logic [2:0]        ready_mask;

	nmea_sentence_checksum_framer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.char_in       (char_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.store_en      (store_en),
		.sentence_type (sentence_type),
		.store_index   (store_index),
		.store_byte    (store_byte),
		.accepted      (accepted),
		.checksum_fail (checksum_fail),
		.ready_mask    (ready_mask)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor state, starting from the post-reset values
	bit                framing = 1'b0;
	logic [HCNT_W-1:0] hunt_pos [NUM_TYPES] = '{default: '0};
	sent_type_t        frame_kind = TYPE_RMC;
	logic [BLEN_W-1:0] body_count = '0;
	byte_t             run_sum = '0;
	byte_t             rx_sum = '0;
	logic [6:0]        digit_count = '0;
	logic [2:0]        flag_bits = '0;

	frame_out_t outs_due [$];
	typed_out_t typed_outs [$];

	int errors = 0;
	int items_sent = 0;
	int n_results = 0;
	int n_pass = 0;
	int n_sum_bad = 0;
	int n_flag_drop = 0;
	int n_limit = 0;
	int n_clear = 0;
	bit idle_on = 1'b1;

	task automatic note_error(string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic frame_out_t mk_out(logic se, sent_type_t k, int idx, byte_t d,
			logic ok, logic bad, logic [2:0] m);
		frame_out_t r;
		r.store_en = se;
		r.kind     = k;
		r.index    = idx[BLEN_W-1:0];
		r.data     = d;
		r.sum_ok   = ok;
		r.sum_bad  = bad;
		r.flags    = m;
		return r;
	endfunction

	// Framer behavior for one transfer; advances the predictor state
	function automatic frame_out_t frame_item(opcode_t op, byte_t c);
		frame_out_t r;
		logic [2:0] bit_m;
		bit         finish;
		bit         done;
		byte_t      nib;
		r = '0;
		if (op == OP_RELEASE) begin
			if (flag_bits == 3'b111) begin
				flag_bits = '0;
				n_clear++;
			end
		end else if (!framing) begin
			// header hunt: a mismatch resets the counter, no second look at the byte
			done = 1'b0;
			for (int t = 0; t < NUM_TYPES; t++) begin
				if (!done) begin
					if (hunt_pos[t] < HDR_LEN && c == HDR_TEXT[t][hunt_pos[t]]) begin
						hunt_pos[t]++;
						if (hunt_pos[t] == HDR_LEN) begin
							frame_kind = sent_type_t'(t);
							framing    = 1'b1;
							body_count = '0;
							run_sum    = HDR_SEED[t];
							for (int k = 0; k < NUM_TYPES; k++) hunt_pos[k] = '0;
							r.kind = frame_kind;
							done   = 1'b1;
						end
					end else begin
						hunt_pos[t] = '0;
					end
				end
			end
		end else begin
			bit_m  = 3'b001 << frame_kind;
			r.kind = frame_kind;
			finish = 1'b0;
			if ((flag_bits & bit_m) != 0) begin
				// flag still set: sentence dropped on its first body byte
				finish = 1'b1;
				n_flag_drop++;
			end else begin
				if (body_count == 0) begin
					digit_count = '0;
					rx_sum      = '0;
				end
				if (c == CHAR_CR) begin
					if (rx_sum == run_sum) begin
						flag_bits = flag_bits | bit_m;
						r.sum_ok  = 1'b1;
						n_pass++;
					end else begin
						r.sum_bad = 1'b1;
						n_sum_bad++;
					end
					finish = 1'b1;
				end else begin
					if (c == CHAR_STAR) begin
						rx_sum      = '0;
						digit_count = 7'd1;
					end else if (digit_count != 0) begin
						// digits are ORed in; only the first one gets shifted up
						if (c >= CHAR_0 && c <= CHAR_9) nib = c - CHAR_0;
						else nib = c - HEX_ALPHA;
						rx_sum = rx_sum | nib;
						if (digit_count == 1) rx_sum = rx_sum << 4;
						if (digit_count < 127) digit_count++;
					end else begin
						run_sum = run_sum ^ c;
					end
					r.store_en = 1'b1;
					r.index    = body_count;
					r.data     = c;
				end
			end
			if (finish) begin
				framing = 1'b0;
				for (int k = 0; k < NUM_TYPES; k++) hunt_pos[k] = '0;
			end else begin
				body_count++;
				if (body_count >= MAX_BODY_LEN) begin
					framing = 1'b0;
					for (int k = 0; k < NUM_TYPES; k++) hunt_pos[k] = '0;
					n_limit++;
				end
			end
		end
		r.flags = flag_bits;
		return r;
	endfunction

	function automatic int pause_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80) return $urandom_range(1, 2);
		if (p < 97) return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	function automatic byte_t hex_char(logic [3:0] n);
		if (n < 10) return CHAR_0 + byte_t'(n);
		return HEX_ALPHA + byte_t'(n);
	endfunction

	// Input transfer monitor: predict on every accepted item
	always @(posedge clk) begin : in_mon
		frame_out_t p;
		typed_out_t s;
		if (in_valid && in_ready) begin
			p = frame_item(opcode_t'(opcode), char_in);
			if (typed_outs.size() != 0) begin
				s = typed_outs.pop_front();
				if (s.typed) p = s.want;
			end
			outs_due.push_back(p);
		end
	end

	// Output transfer monitor: compare with the oldest expectation
	always @(posedge clk) begin : out_mon
		frame_out_t want;
		if (out_valid && out_ready) begin
			n_results++;
			if (outs_due.size() == 0) begin
				note_error($sformatf("result %0d arrived with nothing pending", n_results));
			end else begin
				want = outs_due.pop_front();
				if (store_en !== want.store_en)
					note_error($sformatf("result %0d store_en got %b want %b",
						n_results, store_en, want.store_en));
				if (sentence_type !== want.kind)
					note_error($sformatf("result %0d sentence_type got %0d want %0d",
						n_results, sentence_type, want.kind));
				if (store_index !== want.index)
					note_error($sformatf("result %0d store_index got %0d want %0d",
						n_results, store_index, want.index));
				if (store_byte !== want.data)
					note_error($sformatf("result %0d store_byte got %h want %h",
						n_results, store_byte, want.data));
				if (accepted !== want.sum_ok)
					note_error($sformatf("result %0d accepted got %b want %b",
						n_results, accepted, want.sum_ok));
				if (checksum_fail !== want.sum_bad)
					note_error($sformatf("result %0d checksum_fail got %b want %b",
						n_results, checksum_fail, want.sum_bad));
				if (ready_mask !== want.flags)
					note_error($sformatf("result %0d ready_mask got %b want %b",
						n_results, ready_mask, want.flags));
			end
		end
	end

	// Receiver side stalls
	initial begin : sink
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 6) == 0) stall_left = pause_len();
			end
		end
	end

	task automatic send(opcode_t op, byte_t ch);
		int gap;
		in_valid <= 1'b1;
		opcode   <= op;
		char_in  <= ch;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = pause_len();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_row(opcode_t op, byte_t ch, bit typed, frame_out_t want);
		typed_outs.push_back('{typed, want});
		send(op, ch);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_row(OP_BYTE, s[i], 1'b0, '0);
	endtask

	// Mostly well-formed sentence with random body and a mostly correct checksum
	task automatic send_sentence(int t);
		byte_t sum;
		byte_t b;
		byte_t hi;
		byte_t lo;
		int    len;
		int    v;
		for (int k = 0; k < HDR_LEN; k++) send(OP_BYTE, HDR_TEXT[t][k]);
		sum = HDR_SEED[t];
		len = ($urandom_range(0, 99) < 6) ? $urandom_range(60, 90) : $urandom_range(0, 20);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 4) != 0) b = byte_t'($urandom_range(32, 126));
			else b = byte_t'($urandom_range(0, 255));
			if (b == CHAR_STAR || b == CHAR_CR) b = 8'h2C;
			sum = sum ^ b;
			send(OP_BYTE, b);
			if ($urandom_range(0, 99) < 3) send(OP_RELEASE, byte_t'($urandom_range(0, 255)));
		end
		v = $urandom_range(0, 99);
		if (v < 94) begin
			send(OP_BYTE, CHAR_STAR);
			if (v >= 60 && v < 72) sum = sum ^ byte_t'($urandom_range(1, 255));
			hi = hex_char(sum[7:4]);
			lo = hex_char(sum[3:0]);
			// lower-case letters do not map to the right digit values
			if (v >= 72 && v < 78) begin
				if (hi > CHAR_9) hi = hi + 8'h20;
				if (lo > CHAR_9) lo = lo + 8'h20;
			end
			send(OP_BYTE, hi);
			if (!(v >= 78 && v < 84)) send(OP_BYTE, lo);
			if (v >= 84) begin
				repeat ($urandom_range(1, 3)) send(OP_BYTE, byte_t'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 99) < 97) send(OP_BYTE, CHAR_CR);
	endtask

	initial begin : stim
		int pick;
		int plen;
		int t2;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: release with no flags, byte extremes while hunting
		send_row(OP_RELEASE, 8'hFF, 1'b1, mk_out(0, TYPE_RMC, 0, 8'h00, 0, 0, 3'b000));
		send_row(OP_BYTE, 8'h00, 1'b1, mk_out(0, TYPE_RMC, 0, 8'h00, 0, 0, 3'b000));
		send_row(OP_BYTE, 8'hFF, 1'b1, mk_out(0, TYPE_RMC, 0, 8'h00, 0, 0, 3'b000));
		// RMC sentence "GPRMC,A*26" then CR: good checksum
		send_text("GPRMC");
		send_row(OP_BYTE, ",", 1'b1, mk_out(0, TYPE_RMC, 0, 8'h00, 0, 0, 3'b000));
		send_row(OP_BYTE, "A", 1'b1, mk_out(1, TYPE_RMC, 0, "A", 0, 0, 3'b000));
		send_row(OP_BYTE, CHAR_STAR, 1'b1, mk_out(1, TYPE_RMC, 1, CHAR_STAR, 0, 0, 3'b000));
		send_row(OP_BYTE, "2", 1'b1, mk_out(1, TYPE_RMC, 2, "2", 0, 0, 3'b000));
		send_row(OP_BYTE, "6", 1'b1, mk_out(1, TYPE_RMC, 3, "6", 0, 0, 3'b000));
		send_row(OP_BYTE, CHAR_CR, 1'b1, mk_out(0, TYPE_RMC, 0, 8'h00, 1, 0, 3'b001));
		// RMC again while its flag is set: dropped on the first body byte
		send_text("GPRMC");
		send_row(OP_BYTE, ",", 1'b1, mk_out(0, TYPE_RMC, 0, 8'h00, 0, 0, 3'b001));
		send_row(OP_BYTE, "X", 1'b1, mk_out(0, TYPE_RMC, 0, 8'h00, 0, 0, 3'b001));
		// GSA with CR right after the header: checksum mismatch
		send_text("GPGSA");
		send_row(OP_BYTE, ",", 1'b1, mk_out(0, TYPE_GSA, 0, 8'h00, 0, 0, 3'b001));
		send_row(OP_BYTE, CHAR_CR, 1'b1, mk_out(0, TYPE_GSA, 0, 8'h00, 0, 1, 3'b001));

		// Random: mostly sentences, some broken headers, noise and releases
		while (items_sent < ITEM_TARGET) begin
			idle_on = ((items_sent / 300) % 4) != 3;
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_sentence($urandom_range(0, NUM_TYPES - 1));
			end else if (pick < 80) begin
				t2   = $urandom_range(0, NUM_TYPES - 1);
				plen = $urandom_range(1, HDR_LEN - 1);
				for (int k = 0; k < plen; k++) send(OP_BYTE, HDR_TEXT[t2][k]);
				send_sentence($urandom_range(0, NUM_TYPES - 1));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 8)) send(OP_BYTE, byte_t'($urandom_range(0, 255)));
			end else begin
				send(OP_RELEASE, byte_t'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 2) == 0) send(OP_RELEASE, byte_t'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;

		// Drain, then allow for the pipeline latency
		@(posedge clk);
		for (int w = 0; w < 4000 && outs_due.size() != 0; w++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (outs_due.size() != 0)
			note_error($sformatf("%0d expected results never arrived", outs_due.size()));

		$display("Run: %0d items in, %0d results; %0d sentences accepted, %0d bad checksums,",
			items_sent, n_results, n_pass, n_sum_bad);
		$display("     %0d dropped on a set flag, %0d cut at the length limit, %0d flag clears.",
			n_flag_drop, n_limit, n_clear);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin : watchdog
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
